FILE: src/pip_pkg.sv
// Shared types and constants for the even-odd point-in-polygon block.
// No dependencies; imported by pip_edge, point_in_polygon_even_odd and the testbench.
package pip_pkg;

	// Fixed widths of the request and response fields
	localparam int COORD_W = 16;
	localparam int COUNT_W = 7;

	// Request mode codes
	localparam logic MODE_VERTEX = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef struct packed {
		logic                      mode;
		logic                      restart;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
	} req_t;

	typedef struct packed {
		logic               inside_res;
		logic [COUNT_W-1:0] crossing_count;
		logic               truncated;
	} rsp_t;

	// Operation of the shared edge multiplier
	typedef enum logic [1:0] {
		EOP_IDLE = 2'b00,
		EOP_LHS  = 2'b01,
		EOP_RHS  = 2'b10
	} edge_op_t;

endpackage

FILE: src/pip_vstore.sv
// Vertex store: one write port, one registered read port, no reset on the array.
// Depends on nothing; instantiated by point_in_polygon_even_odd.
module pip_vstore #(
	parameter int DEPTH = 64,
	parameter int CB    = 16,
	parameter int AW    = 6
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [CB-1:0] wx,
	input  logic signed [CB-1:0] wy,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic signed [CB-1:0] rx,
	output logic signed [CB-1:0] ry
);

	logic [2*CB-1:0] mem [DEPTH];
	logic [2*CB-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wx, wy};
		end
	end

	// Read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rx = rdata_q[2*CB-1:CB];
	assign ry = rdata_q[CB-1:0];

endmodule

FILE: src/pip_edge.sv
// Shared edge unit: one signed multiplier used twice per edge, then a compare.
// Depends on pip_pkg for the operation code.
module pip_edge
	import pip_pkg::*;
#(
	parameter int CB = 16
) (
	input  logic                 clk,
	input  edge_op_t             op,
	input  logic signed [CB-1:0] ax,
	input  logic signed [CB-1:0] ay,
	input  logic signed [CB-1:0] bx,
	input  logic signed [CB-1:0] by,
	input  logic signed [CB-1:0] px,
	input  logic signed [CB-1:0] py,
	output logic                 hit
);

	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;

	logic signed [DW-1:0] mul_a;
	logic signed [DW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] lhs_q;
	logic signed [PW-1:0] rhs_q;
	logic                 strad_q;
	logic                 up_q;

	// Operand select: (px-ax)*(by-ay) or (py-ay)*(bx-ax)
	always_comb begin
		case (op)
			EOP_LHS: begin
				mul_a = DW'(px) - DW'(ax);
				mul_b = DW'(by) - DW'(ay);
			end
			EOP_RHS: begin
				mul_a = DW'(py) - DW'(ay);
				mul_b = DW'(bx) - DW'(ax);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Product registers; straddle and direction taken with the first product
	always_ff @(posedge clk) begin
		case (op)
			EOP_LHS: begin
				lhs_q   <= prod;
				strad_q <= ((ay <= py) && (by > py)) || ((by <= py) && (ay > py));
				up_q    <= by > ay;
			end
			EOP_RHS: begin
				rhs_q <= prod;
			end
			default: begin
			end
		endcase
	end

	// Downward edge flips the comparison
	assign hit = strad_q && (up_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));

endmodule

FILE: src/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon test: top level with the sequencer and the result register.
// Depends on pip_pkg, pip_vstore and pip_edge.
//
// A vertex request (mode 0) appends to a store of MAX_VERTICES entries; restart empties
// the polygon first, and a vertex beyond the store is dropped and sets the truncated flag.
// A query request (mode 1) walks every edge, the closing one included, and yields one
// response. A query holds the request side until its response is loaded into the output
// register, which happens only once the previous response there has been taken. One
// shared multiplier forms the two cross products of each edge in states S_E1 and S_E2,
// and S_E3 compares and counts, while the next vertex is read from the store's single
// read port. A finished response waits in an output register, and vertex requests are
// taken while it waits. The store needs no clearing after reset.
module point_in_polygon_even_odd
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CB = COORD_BITS;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD0 = 7'b0000010,
		S_LOADB = 7'b0000100,
		S_E1    = 7'b0001000,
		S_E2    = 7'b0010000,
		S_E3    = 7'b0100000,
		S_DONE  = 7'b1000000
	} st_t;

	st_t                  state_q;
	logic [CW-1:0]        cnt_q;
	logic                 ovf_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        cross_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic signed [CB-1:0] px_q, py_q;
	logic signed [CB-1:0] fx_q, fy_q;
	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;

	logic                 acc, acc_vtx, acc_qry;
	logic signed [31:0]   cx32, cy32;
	logic signed [CB-1:0] cx, cy;
	logic [CW-1:0]        base_cnt;
	logic                 store_full;
	logic                 mem_we, mem_re;
	logic [AW-1:0]        mem_raddr;
	logic signed [CB-1:0] rd_x, rd_y;
	logic [CW-1:0]        idx_inc;
	logic [CW:0]          idx_two;
	logic                 more_rd;
	logic                 last_edge;
	logic                 rsp_free;
	logic [31:0]          cross32;
	edge_op_t             eop;
	logic                 hit;

	// Request decode
	assign req_stall = (state_q != S_IDLE);
	assign acc       = req_valid && !req_stall;
	assign acc_vtx   = acc && (req.mode == MODE_VERTEX);
	assign acc_qry   = acc && (req.mode == MODE_QUERY);

	// Coordinates to COORD_BITS two's complement
	assign cx32 = 32'(req.coord_x);
	assign cy32 = 32'(req.coord_y);
	assign cx   = cx32[CB-1:0];
	assign cy   = cy32[CB-1:0];

	// Append slot
	assign base_cnt   = req.restart ? '0 : cnt_q;
	assign store_full = (base_cnt == CW'(MAX_VERTICES));
	assign mem_we     = acc_vtx && !store_full;

	// Edge walk indexes
	assign idx_inc   = idx_q + CW'(1);
	assign idx_two   = {1'b0, idx_q} + (CW+1)'(2);
	assign more_rd   = idx_two < {1'b0, cnt_q};
	assign last_edge = (idx_inc == cnt_q);

	// Store read control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_re = acc_qry && (cnt_q != '0);
			end
			S_LOAD0: begin
				mem_re    = (cnt_q > CW'(1));
				mem_raddr = AW'(1);
			end
			S_E1: begin
				mem_re    = more_rd;
				mem_raddr = idx_two[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Multiplier operation per state
	always_comb begin
		case (state_q)
			S_E1:    eop = EOP_LHS;
			S_E2:    eop = EOP_RHS;
			default: eop = EOP_IDLE;
		endcase
	end

	pip_vstore #(
		.DEPTH (MAX_VERTICES),
		.CB    (CB),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (base_cnt[AW-1:0]),
		.wx    (cx),
		.wy    (cy),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rx    (rd_x),
		.ry    (rd_y)
	);

	pip_edge #(
		.CB (CB)
	) u_edge (
		.clk (clk),
		.op  (eop),
		.ax  (ax_q),
		.ay  (ay_q),
		.bx  (bx_q),
		.by  (by_q),
		.px  (px_q),
		.py  (py_q),
		.hit (hit)
	);

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Sequencer and polygon bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			idx_q       <= '0;
			cross_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response register: load a finished query, else drain when taken
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc_vtx) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= base_cnt + CW'(1);
							ovf_q <= req.restart ? 1'b0 : ovf_q;
						end
					end else if (acc_qry) begin
						idx_q   <= '0;
						cross_q <= '0;
						state_q <= (cnt_q == '0) ? S_DONE : S_LOAD0;
					end
				end
				S_LOAD0: begin
					state_q <= (cnt_q == CW'(1)) ? S_E1 : S_LOADB;
				end
				S_LOADB: begin
					state_q <= S_E1;
				end
				S_E1: begin
					state_q <= S_E2;
				end
				S_E2: begin
					state_q <= S_E3;
				end
				S_E3: begin
					cross_q <= cross_q + CW'(hit);
					idx_q   <= idx_inc;
					state_q <= last_edge ? S_DONE : S_E1;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cross32 = 32'(cross_q);

	// Query point, first vertex, current edge and response payload
	always_ff @(posedge clk) begin
		if (acc_qry) begin
			px_q <= cx;
			py_q <= cy;
		end
		case (state_q)
			S_LOAD0: begin
				fx_q <= rd_x;
				fy_q <= rd_y;
				ax_q <= rd_x;
				ay_q <= rd_y;
				bx_q <= rd_x;
				by_q <= rd_y;
			end
			S_LOADB: begin
				bx_q <= rd_x;
				by_q <= rd_y;
			end
			S_E3: begin
				ax_q <= bx_q;
				ay_q <= by_q;
				bx_q <= more_rd ? rd_x : fx_q;
				by_q <= more_rd ? rd_y : fy_q;
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_q.inside_res     <= cross_q[0];
					rsp_q.crossing_count <= cross32[COUNT_W-1:0];
					rsp_q.truncated      <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_VERTICES))
		else $error("vertex count above store depth");

	a_ovf_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(acc_vtx && store_full))
		else $error("truncation flag set without a dropped vertex");

	a_cross_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cross_q <= idx_q)
		else $error("more crossings than edges visited");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_free) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished query not handed to the response register");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for point_in_polygon_even_odd: random polygons and queries
// against a scoreboard that keeps its own copy of the polygon store.
// Depends on pip_pkg and the point_in_polygon_even_odd RTL.

import pip_pkg::*;

localparam int POLY_DEPTH = 64;

// Scoreboard: tracks the polygon, predicts each query answer, checks responses
class pip_scoreboard;
	logic signed [COORD_W-1:0] poly_x [POLY_DEPTH];
	logic signed [COORD_W-1:0] poly_y [POLY_DEPTH];
	int unsigned n_verts;
	bit          dropped_flag;
	rsp_t        expected_answers [$];
	int unsigned errors;
	int unsigned vertex_reqs, dropped_reqs, query_reqs, inside_answers, max_crossings;

	function new();
		n_verts = 0;
		dropped_flag = 0;
		errors = 0;
		vertex_reqs = 0;
		dropped_reqs = 0;
		query_reqs = 0;
		inside_answers = 0;
		max_crossings = 0;
	endfunction

	// Half-open straddle in y, then exact left-of-crossing test without division
	function automatic bit edge_crosses(longint ax, longint ay, longint bx, longint by,
			longint qx, longint qy);
		longint dy, lhs, rhs;
		if (!((ay <= qy && by > qy) || (by <= qy && ay > qy)))
			return 1'b0;
		dy  = by - ay;
		lhs = (qx - ax) * dy;
		rhs = (qy - ay) * (bx - ax);
		if (dy > 0)
			return lhs < rhs;
		return lhs > rhs;
	endfunction

	// Walk every stored edge, closing edge included
	function automatic int unsigned count_crossings(longint qx, longint qy);
		int unsigned hits, j;
		hits = 0;
		for (int unsigned i = 0; i < n_verts; i++) begin
			j = (i + 1 < n_verts) ? i + 1 : 0;
			hits += edge_crosses(longint'(poly_x[i]), longint'(poly_y[i]),
				longint'(poly_x[j]), longint'(poly_y[j]), qx, qy);
		end
		return hits;
	endfunction

	function void note_request(req_t r);
		int unsigned hits;
		rsp_t        ans;
		if (r.mode == MODE_VERTEX) begin
			vertex_reqs++;
			if (r.restart) begin
				n_verts = 0;
				dropped_flag = 0;
			end
			if (n_verts < POLY_DEPTH) begin
				poly_x[n_verts] = r.coord_x;
				poly_y[n_verts] = r.coord_y;
				n_verts++;
			end else begin
				dropped_flag = 1;
				dropped_reqs++;
			end
		end else begin
			query_reqs++;
			hits = count_crossings(longint'(r.coord_x), longint'(r.coord_y));
			ans.inside_res     = hits[0];
			ans.crossing_count = hits[COUNT_W-1:0];
			ans.truncated      = dropped_flag;
			if (hits[0])
				inside_answers++;
			if (hits > max_crossings)
				max_crossings = hits;
			expected_answers.push_back(ans);
		end
	endfunction

	function void check_response(rsp_t got);
		rsp_t want;
		if (expected_answers.size() == 0) begin
			$error("response with no query outstanding: inside_res %0d crossing_count %0d",
				got.inside_res, got.crossing_count);
			errors++;
			return;
		end
		want = expected_answers.pop_front();
		if (got.inside_res !== want.inside_res) begin
			$error("inside_res: expected %0d, got %0d", want.inside_res, got.inside_res);
			errors++;
		end
		if (got.crossing_count !== want.crossing_count) begin
			$error("crossing_count: expected %0d, got %0d",
				want.crossing_count, got.crossing_count);
			errors++;
		end
		if (got.truncated !== want.truncated) begin
			$error("truncated: expected %0d, got %0d", want.truncated, got.truncated);
			errors++;
		end
	endfunction

	function int unsigned pending();
		return expected_answers.size();
	endfunction

	function void report_leftover();
		if (expected_answers.size() != 0) begin
			$error("%0d query answers never arrived", expected_answers.size());
			errors++;
		end
	endfunction
endclass

module tb;

	localparam int TOTAL_ITEMS    = 850;
	localparam int QUIET_FROM     = 720;
	localparam int HOLD_AT        = 300;
	localparam int DRAIN_AT       = 500;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 250;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pip_scoreboard sb = new();

	bit          no_idle  = 1'b0;
	bit          hold_req = 1'b0;
	bit          hold_done, drain_done;
	int unsigned items_sent = 0;
	int          cur_span;
	logic signed [COORD_W-1:0] shape_x [$];
	logic signed [COORD_W-1:0] shape_y [$];

	point_in_polygon_even_odd #(
		.MAX_VERTICES(POLY_DEPTH),
		.COORD_BITS  (COORD_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one request at a falling edge, hold it until accepted
	task automatic issue_request(logic md, logic rs, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		req_t r;
		int   gap;
		r.mode    = md;
		r.restart = rs;
		r.coord_x = x;
		r.coord_y = y;
		gap = 0;
		if (!no_idle && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		items_sent++;
		@(negedge clk);
	endtask

	// Sender pause until all answers are back
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Mostly small offsets (many exact ties), sometimes full range or extremes
	function automatic logic signed [COORD_W-1:0] coord_near(int span);
		int d;
		case ($urandom_range(0, 7))
			0: return COORD_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return -32768;
					1: return 32767;
					2: return 0;
					default: return -1;
				endcase
			end
			default: begin
				d = int'($urandom_range(0, 2 * span)) - span;
				return COORD_W'(d);
			end
		endcase
	endfunction

	// Query point: on a vertex, on a vertex's y line, or anywhere nearby
	task automatic issue_query(logic rs);
		int k;
		if (shape_x.size() != 0 && $urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, shape_x.size() - 1);
			issue_request(MODE_QUERY, rs, shape_x[k], shape_y[k]);
		end else if (shape_x.size() != 0 && $urandom_range(0, 2) == 0) begin
			k = $urandom_range(0, shape_x.size() - 1);
			issue_request(MODE_QUERY, rs, coord_near(cur_span), shape_y[k]);
		end else begin
			issue_request(MODE_QUERY, rs, coord_near(cur_span), coord_near(cur_span));
		end
	endtask

	// One polygon (n vertices, n = 0 picks at random) followed by a few queries
	task automatic polygon_sequence(int n);
		int nq, sel;
		logic signed [COORD_W-1:0] x, y;
		logic rs;
		sel = $urandom_range(0, 9);
		if (n == 0) begin
			if (sel == 0)
				n = $urandom_range(58, 70);
			else if (sel == 1)
				n = $urandom_range(1, 2);
			else
				n = $urandom_range(3, 10);
		end
		case ($urandom_range(0, 2))
			0: cur_span = 12;
			1: cur_span = 300;
			default: cur_span = 32767;
		endcase
		// occasionally extend the previous polygon instead of restarting
		rs = ($urandom_range(0, 9) != 0);
		if (rs) begin
			shape_x.delete();
			shape_y.delete();
		end
		for (int i = 0; i < n; i++) begin
			x = coord_near(cur_span);
			y = coord_near(cur_span);
			shape_x.push_back(x);
			shape_y.push_back(y);
			issue_request(MODE_VERTEX, (i == 0) ? rs : 1'b0, x, y);
		end
		nq = $urandom_range(1, 6);
		for (int i = 0; i < nq; i++) begin
			// noise: restart set on a query, or a stray vertex mid-stream
			if ($urandom_range(0, 11) == 0) begin
				issue_query(1'b1);
			end else if ($urandom_range(0, 15) == 0) begin
				x = coord_near(cur_span);
				y = coord_near(cur_span);
				shape_x.push_back(x);
				shape_y.push_back(y);
				issue_request(MODE_VERTEX, 1'b0, x, y);
			end else begin
				issue_query(1'b0);
			end
		end
	endtask

	// Response side: checks at rising edge, random stall bursts, one long hold-off
	initial begin : rsp_side
		int burst_left, hold_left;
		burst_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (no_idle) begin
				burst_left = 0;
				rsp_stall <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(1, 17) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Watchdog: cycles in a row with no request or response accepted
	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("point_in_polygon_even_odd: mismatch");
		$finish;
	end

	initial begin : stimulus
		hold_done  = 1'b0;
		drain_done = 1'b0;
		cur_span   = 12;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty polygon straight after reset
		issue_request(MODE_QUERY, 1'b0, 0, 0);
		// single vertex: degenerate edge
		issue_request(MODE_VERTEX, 1'b1, 5, 5);
		issue_request(MODE_QUERY, 1'b0, 0, 5);
		// two vertices: segment walked both ways
		issue_request(MODE_VERTEX, 1'b1, 0, -10);
		issue_request(MODE_VERTEX, 1'b0, 0, 10);
		issue_request(MODE_QUERY, 1'b0, -5, 0);
		issue_request(MODE_QUERY, 1'b0, 5, 0);
		// full-range square: horizontal and downward edges, corners, borders
		issue_request(MODE_VERTEX, 1'b1, -32768, -32768);
		issue_request(MODE_VERTEX, 1'b0, 32767, -32768);
		issue_request(MODE_VERTEX, 1'b0, 32767, 32767);
		issue_request(MODE_VERTEX, 1'b0, -32768, 32767);
		issue_request(MODE_QUERY, 1'b0, 0, 0);
		issue_request(MODE_QUERY, 1'b0, -32768, -32768);
		issue_request(MODE_QUERY, 1'b0, 32767, 32767);
		issue_request(MODE_QUERY, 1'b0, -32768, 0);
		issue_request(MODE_QUERY, 1'b0, 32767, 0);
		// restart on a query is ignored
		issue_request(MODE_QUERY, 1'b1, 0, -1);
		issue_request(MODE_QUERY, 1'b0, 0, 32766);

		// store overflow: more vertices than the store holds
		shape_x.delete();
		shape_y.delete();
		polygon_sequence(POLY_DEPTH + 3);

		while (items_sent < TOTAL_ITEMS) begin
			no_idle = (items_sent >= 150 && items_sent < 250) || items_sent >= QUIET_FROM;
			if (!hold_done && items_sent >= HOLD_AT) begin
				// long response hold-off while queries keep coming
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (6) issue_query(1'b0);
			end else if (!drain_done && items_sent >= DRAIN_AT) begin
				drain_done = 1'b1;
				wait_drained();
			end else begin
				polygon_sequence(0);
			end
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.report_leftover();

		$display("covered %0d vertex requests (%0d dropped on a full store), %0d queries",
			sb.vertex_reqs, sb.dropped_reqs, sb.query_reqs);
		$display("%0d queries answered inside, largest crossing count %0d",
			sb.inside_answers, sb.max_crossings);
		if (sb.errors == 0) begin
			$display("point_in_polygon_even_odd: match");
		end else begin
			$display("point_in_polygon_even_odd: mismatch");
		end
		$finish;
	end

endmodule

FILE: files.f
src/pip_pkg.sv
src/pip_vstore.sv
src/pip_edge.sv
src/point_in_polygon_even_odd.sv
dv/tb.sv
